FILE: rtl/lpfp_pkg.sv
package lpfp_pkg;

  typedef enum logic [4:0] {
    PH_SINGLE = 5'b00001,
    PH_LENGTH = 5'b00010,
    PH_STRING = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;

  localparam logic [1:0] STATUS_RUNNING = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_ERROR   = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_KINDS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_COUNT = 2'd1;

  localparam int unsigned KIND_SLOTS = 8;

  function automatic phase_t kind_to_phase(input logic [1:0] kind);
    phase_t ph;
    case (kind)
      KIND_LENGTH: ph = PH_LENGTH;
      KIND_STRING: ph = PH_STRING;
      default:     ph = PH_SINGLE;
    endcase
    return ph;
  endfunction

endpackage

FILE: rtl/lpfp_byte_if.sv
interface lpfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/lpfp_result_if.sv
interface lpfp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] field_index;
  logic [7:0] byte_offset;
  logic [7:0] byte_out;
  logic       field_complete;
  logic       consumed;

  modport source (
    output valid, output status, output field_index, output byte_offset,
    output byte_out, output field_complete, output consumed, input ready
  );
  modport sink (
    input valid, input status, input field_index, input byte_offset,
    input byte_out, input field_complete, input consumed, output ready
  );
endinterface

FILE: rtl/lpfp_cfg_if.sv
interface lpfp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpfp_pkg::CFG_INDEX_W-1:0]   index;
  logic [lpfp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/length_prefixed_field_parser.sv
// Length-prefixed field parser.
// Bytes of a message arrive on byte_in, one request per byte. Each byte yields
// one request on result: the status after the byte, the slot that took it, its
// offset within a string body, the byte itself, a field-complete mark and a
// consumed flag. Bytes that arrive after the message is done or in error are
// answered with consumed low and the current status.
// The cfg channel writes field_kinds (index 0) and field_count (index 1); it is
// always ready, and any write to either register restarts the message.
// The result is registered: result valid rises in the cycle after acceptance.
// Throughput is one byte per cycle while results are taken: the parse state
// updates in the accepting cycle; the result sits in a single output register.
// When the receiver stalls, the output register holds and byte_in.ready drops
// until the result is taken or will be taken in the same cycle.
// Synchronous reset clears the registers to all single-byte slots and a field
// count of one, and empties the output register.
module length_prefixed_field_parser #(
  parameter int unsigned MAX_FIELDS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  lpfp_byte_if.sink            byte_in,
  lpfp_result_if.source        result,
  lpfp_cfg_if.sink             cfg
);

  localparam int unsigned PtrW = $clog2(MAX_FIELDS + 2);

  logic [15:0]           field_kinds;
  logic [3:0]            field_count;
  lpfp_pkg::phase_t      phase;
  logic [PtrW-1:0]       slot_pointer;
  logic [7:0]            bytes_left;
  logic [7:0]            body_length;

  logic [15:0]           field_kinds_next;
  logic [3:0]            field_count_next;
  lpfp_pkg::phase_t      phase_next;
  logic [PtrW-1:0]       slot_pointer_next;
  logic [7:0]            bytes_left_next;
  logic [7:0]            body_length_next;

  logic                  out_valid;
  logic [1:0]            out_status;
  logic [2:0]            out_index;
  logic [7:0]            out_offset;
  logic [7:0]            out_byte;
  logic                  out_complete;
  logic                  out_consumed;

  logic [1:0]            st_next;
  logic [2:0]            idx_next;
  logic [7:0]            off_next;
  logic [7:0]            bout_next;
  logic                  comp_next;
  logic                  took_next;

  logic [PtrW-1:0]       slots_used;
  logic [PtrW-1:0]       ptr_plus1;
  logic [PtrW-1:0]       ptr_plus2;
  logic [7:0]            left_dec;
  logic                  accept;
  logic                  cfg_hit;
  logic [4:0]            count_ext;

  function automatic lpfp_pkg::phase_t slot_phase(input logic [15:0] kinds,
                                                  input logic [PtrW-1:0] slot);
    logic [4:0] s;
    lpfp_pkg::phase_t ph;
    s = 5'(slot);
    if (s >= 5'(lpfp_pkg::KIND_SLOTS)) begin
      ph = lpfp_pkg::PH_SINGLE;
    end else begin
      ph = lpfp_pkg::kind_to_phase(kinds[{s[2:0], 1'b0} +: 2]);
    end
    return ph;
  endfunction

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = !out_valid || result.ready;
  assign accept        = byte_in.valid && byte_in.ready;
  assign cfg_hit       = cfg.valid && (cfg.index == lpfp_pkg::REG_FIELD_KINDS ||
                                       cfg.index == lpfp_pkg::REG_FIELD_COUNT);

  always_comb begin
    count_ext = (field_count == 4'd0) ? 5'd1 : {1'b0, field_count};
    if (count_ext > 5'(MAX_FIELDS)) begin
      count_ext = 5'(MAX_FIELDS);
    end
    slots_used = PtrW'(count_ext);
  end

  assign ptr_plus1 = slot_pointer + PtrW'(1);
  assign ptr_plus2 = slot_pointer + PtrW'(2);
  assign left_dec  = bytes_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    slot_pointer_next = slot_pointer;
    bytes_left_next   = bytes_left;
    body_length_next  = body_length;
    idx_next          = 3'd0;
    off_next          = 8'd0;
    bout_next         = 8'd0;
    comp_next         = 1'b0;
    took_next         = 1'b0;

    if (phase != lpfp_pkg::PH_DONE && phase != lpfp_pkg::PH_ERROR) begin
      took_next = 1'b1;
      bout_next = byte_in.data_byte;
      idx_next  = 3'(5'(slot_pointer));
      case (phase)
        lpfp_pkg::PH_LENGTH: begin
          comp_next         = 1'b1;
          slot_pointer_next = ptr_plus1;
          if (ptr_plus1 >= slots_used) begin
            phase_next = lpfp_pkg::PH_ERROR;
          end else begin
            bytes_left_next  = byte_in.data_byte;
            body_length_next = byte_in.data_byte;
            if (byte_in.data_byte == 8'd0) begin
              slot_pointer_next = ptr_plus2;
              if (ptr_plus2 >= slots_used) begin
                phase_next = lpfp_pkg::PH_DONE;
              end else begin
                phase_next = slot_phase(field_kinds, ptr_plus2);
              end
            end else begin
              phase_next = slot_phase(field_kinds, ptr_plus1);
            end
          end
        end
        lpfp_pkg::PH_STRING: begin
          if (bytes_left == 8'd0) begin
            comp_next = 1'b1;
          end else begin
            off_next        = body_length - bytes_left;
            bytes_left_next = left_dec;
            comp_next       = (left_dec == 8'd0);
          end
        end
        default: begin
          comp_next = 1'b1;
        end
      endcase
      if (comp_next && phase != lpfp_pkg::PH_LENGTH) begin
        slot_pointer_next = ptr_plus1;
        if (ptr_plus1 >= slots_used) begin
          phase_next = lpfp_pkg::PH_DONE;
        end else begin
          phase_next = slot_phase(field_kinds, ptr_plus1);
        end
      end
    end

    case (phase_next)
      lpfp_pkg::PH_DONE:  st_next = lpfp_pkg::STATUS_DONE;
      lpfp_pkg::PH_ERROR: st_next = lpfp_pkg::STATUS_ERROR;
      default:            st_next = lpfp_pkg::STATUS_RUNNING;
    endcase
  end

  always_comb begin
    field_kinds_next = field_kinds;
    field_count_next = field_count;
    if (cfg.valid && cfg.index == lpfp_pkg::REG_FIELD_KINDS) begin
      field_kinds_next = cfg.data;
    end
    if (cfg.valid && cfg.index == lpfp_pkg::REG_FIELD_COUNT) begin
      field_count_next = cfg.data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_kinds  <= 16'd0;
      field_count  <= 4'd1;
      phase        <= lpfp_pkg::PH_SINGLE;
      slot_pointer <= '0;
      bytes_left   <= 8'd0;
      body_length  <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      field_kinds <= field_kinds_next;
      field_count <= field_count_next;
      if (cfg_hit) begin
        phase        <= slot_phase(field_kinds_next, '0);
        slot_pointer <= '0;
        bytes_left   <= 8'd0;
        body_length  <= 8'd0;
      end else if (accept) begin
        phase        <= phase_next;
        slot_pointer <= slot_pointer_next;
        bytes_left   <= bytes_left_next;
        body_length  <= body_length_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status   <= st_next;
      out_index    <= idx_next;
      out_offset   <= off_next;
      out_byte     <= bout_next;
      out_complete <= comp_next;
      out_consumed <= took_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.field_index    = out_index;
  assign result.byte_offset    = out_offset;
  assign result.byte_out       = out_byte;
  assign result.field_complete = out_complete;
  assign result.consumed       = out_consumed;

endmodule
